/* design/stream_substring_replace_macros.svh */
// Assertion macros for the checker of the find-and-replace block.
`ifndef STREAM_SUBSTRING_REPLACE_MACROS_SVH
`define STREAM_SUBSTRING_REPLACE_MACROS_SVH

// Check a property while reset is released.
`define SSR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ssr assertion failed");

// Check a property at every edge, reset included.
`define SSR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ssr assertion failed during reset");

`endif

/* design/ssr_pkg.sv */
// Shared types and constants of the streaming find-and-replace block.
package ssr_pkg;

  // Configuration port
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  // Request codes and the line end byte
  localparam logic       REQ_DATA     = 1'b0;
  localparam logic       REQ_EOF      = 1'b1;
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  // Per-cycle commands from the sequencer to the cell row
  typedef struct packed {
    logic shift;   // every cell takes its right neighbor's byte
    logic append;  // the cell at the fill position takes the new byte
  } row_ctl_t;

endpackage

/* design/ssr_cell.sv */
// One cell of the hold row: a held byte and its compare against one pattern byte.
module ssr_cell (
  input  logic                clk,
  input  ssr_pkg::row_ctl_t   ctl,
  input  logic                sel,
  input  logic [7:0]          new_byte,
  input  logic [7:0]          right_byte,
  input  logic [7:0]          pat_byte,
  output logic [7:0]          held_byte,
  output logic                match
);

  logic [7:0] held_r;
  logic [7:0] held_nxt;

  // Shift toward the head, or take the new byte at the fill position
  always_comb begin
    held_nxt = held_r;
    if (ctl.shift) begin
      held_nxt = right_byte;
    end else if (ctl.append && sel) begin
      held_nxt = new_byte;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  assign held_byte = held_r;
  assign match     = (held_r == pat_byte);

endmodule

/* design/ssr_row.sv */
// Row of hold cells; cell 0 is the oldest held byte.
module ssr_row #(
  parameter int MAX_PATTERN = 8,
  parameter int CNT_W       = 4
) (
  input  logic                          clk,
  input  ssr_pkg::row_ctl_t             ctl,
  input  logic [CNT_W-1:0]              fill_pos,
  input  logic [7:0]                    new_byte,
  input  logic [ssr_pkg::CFG_W-1:0]     pat_bytes,
  output logic [7:0]                    head_byte,
  output logic [MAX_PATTERN-1:0]        match
);

  logic [7:0] held [MAX_PATTERN];

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [7:0] right;

    // Feed the tail cell a zero byte on a shift; it is past the fill count then
    if (i == MAX_PATTERN - 1) begin : g_tail
      assign right = 8'd0;
    end else begin : g_mid
      assign right = held[i+1];
    end

    ssr_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .sel        (fill_pos == CNT_W'(i)),
      .new_byte   (new_byte),
      .right_byte (right),
      .pat_byte   (pat_bytes[8*i +: 8]),
      .held_byte  (held[i]),
      .match      (match[i])
    );
  end

  assign head_byte = held[0];

endmodule

/* design/stream_substring_replace.sv */
// Streaming find-and-replace: top level with sequencer, configuration and output stage.
// Steps: a data byte is appended to the hold row, held bytes are released until the rest
//   is a pattern prefix, a full match is replaced, and the run is closed; a newline, or
//   an end of file on an open line, flushes the held bytes and a newline, then closes.
// No new item is taken until the run is closed. Reset: synchronous, active low; clears
//   hold count, line flag, output valid and registers; pattern length resets to one.
module stream_substring_replace #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ssr_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ssr_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [ssr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssr_pkg::CFG_W-1:0]       cfg_data
);

  localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
  localparam int RCNT_W = $clog2(MAX_REPLACEMENT + 2);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_REPL  = 3'd2;
  localparam logic [2:0] ST_FLUSH = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         line_r, line_nxt;
  logic [RCNT_W-1:0]            k_r, k_nxt;
  logic [ssr_pkg::CFG_W-1:0]    pat_r, pat_nxt;
  logic [ssr_pkg::CFG_W-1:0]    rep_r, rep_nxt;
  logic [CNT_W-1:0]             plen_r, plen_nxt;
  logic [RCNT_W-1:0]            rlen_r, rlen_nxt;
  logic [7:0]                   pend_r, pend_nxt;
  logic                         pend_valid_r, pend_valid_nxt;
  logic                         out_valid_r, out_valid_nxt;
  ssr_pkg::out_t                out_r, out_nxt;

  ssr_pkg::row_ctl_t            row_ctl;
  logic [7:0]                   head_byte;
  logic [MAX_PATTERN-1:0]       match;
  logic [MAX_PATTERN-1:0]       below_count;
  logic                         prefix;
  logic                         out_free;
  logic                         can_emit;
  logic                         emit;
  logic [7:0]                   emit_byte;
  logic                         fin_push;
  logic [ssr_pkg::LEN_W-1:0]    len_val;
  logic [CNT_W-1:0]             plen_eff;
  logic [RCNT_W-1:0]            rlen_eff;

  ssr_row #(
    .MAX_PATTERN (MAX_PATTERN),
    .CNT_W       (CNT_W)
  ) u_row (
    .clk       (clk),
    .ctl       (row_ctl),
    .fill_pos  (count_r),
    .new_byte  (in_data.data_byte),
    .pat_bytes (pat_r),
    .head_byte (head_byte),
    .match     (match)
  );

  // Held bytes form a prefix of the pattern
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      below_count[i] = CNT_W'(i) < count_r;
    end
  end
  assign prefix = (&(match | ~below_count)) && (count_r <= plen_r);

  assign out_free = !out_valid_r || !out_stall;
  assign can_emit = !pend_valid_r || out_free;
  assign in_stall = (state_r != ST_IDLE);

  // Clamp configured lengths to the supported ranges
  assign len_val = cfg_data[ssr_pkg::LEN_W-1:0];
  always_comb begin
    if (len_val == '0) begin
      plen_eff = CNT_W'(1);
    end else if (len_val > ssr_pkg::LEN_W'(MAX_PATTERN)) begin
      plen_eff = CNT_W'(MAX_PATTERN);
    end else begin
      plen_eff = CNT_W'(len_val);
    end
    if (len_val > ssr_pkg::LEN_W'(MAX_REPLACEMENT)) begin
      rlen_eff = RCNT_W'(MAX_REPLACEMENT);
    end else begin
      rlen_eff = RCNT_W'(len_val);
    end
  end

  // Sequencer: append, release, replace, flush, close the run
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    line_nxt  = line_r;
    k_nxt     = k_r;
    pat_nxt   = pat_r;
    rep_nxt   = rep_r;
    plen_nxt  = plen_r;
    rlen_nxt  = rlen_r;
    row_ctl   = '0;
    emit      = 1'b0;
    emit_byte = head_byte;
    fin_push  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == ssr_pkg::REQ_EOF) begin
            if (line_r || count_r != '0) begin
              state_nxt = ST_FLUSH;
            end else begin
              state_nxt = ST_FIN;
            end
          end else if (in_data.data_byte == ssr_pkg::NEWLINE_BYTE) begin
            state_nxt = ST_FLUSH;
          end else begin
            row_ctl.append = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
            line_nxt       = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (count_r == '0) begin
          state_nxt = ST_FIN;
        end else if (prefix) begin
          if (count_r == plen_r) begin
            count_nxt = '0;
            k_nxt     = '0;
            state_nxt = (rlen_r != '0) ? ST_REPL : ST_FIN;
          end else begin
            state_nxt = ST_FIN;
          end
        end else if (can_emit) begin
          // Release the head byte and check the rest again
          emit          = 1'b1;
          row_ctl.shift = 1'b1;
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      ST_REPL: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = rep_r[8*k_r +: 8];
          k_nxt     = k_r + RCNT_W'(1);
          if (RCNT_W'(k_r + RCNT_W'(1)) == rlen_r) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FLUSH: begin
        if (can_emit) begin
          emit = 1'b1;
          if (count_r != '0) begin
            row_ctl.shift = 1'b1;
            count_nxt     = count_r - CNT_W'(1);
          end else begin
            emit_byte = ssr_pkg::NEWLINE_BYTE;
            line_nxt  = 1'b0;
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          fin_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Register writes; a pattern length no longer than the hold count drops the hold
    if (cfg_we) begin
      case (cfg_index)
        ssr_pkg::REG_PATTERN_BYTES: begin
          pat_nxt = cfg_data;
        end
        ssr_pkg::REG_PATTERN_LENGTH: begin
          plen_nxt = plen_eff;
          if (count_r >= plen_eff) begin
            count_nxt = '0;
          end
        end
        ssr_pkg::REG_REPLACEMENT_BYTES: begin
          rep_nxt = cfg_data;
        end
        ssr_pkg::REG_REPLACEMENT_LENGTH: begin
          rlen_nxt = rlen_eff;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold one byte back so the last byte of a run can be marked
  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      pend_nxt       = emit_byte;
      pend_valid_nxt = 1'b1;
      if (pend_valid_r) begin
        out_nxt.out_byte    = pend_r;
        out_nxt.last_of_run = 1'b0;
        out_valid_nxt       = 1'b1;
      end
    end else if (fin_push) begin
      out_nxt.out_byte    = pend_r;
      out_nxt.last_of_run = 1'b1;
      out_valid_nxt       = 1'b1;
      pend_valid_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      line_r       <= 1'b0;
      pat_r        <= '0;
      rep_r        <= '0;
      plen_r       <= CNT_W'(1);
      rlen_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      line_r       <= line_nxt;
      pat_r        <= pat_nxt;
      rep_r        <= rep_nxt;
      plen_r       <= plen_nxt;
      rlen_r       <= rlen_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/ssr_checker.sv */
// Port-level checker for the find-and-replace block, bound to the top level.
`include "stream_substring_replace_macros.svh"

module ssr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input ssr_pkg::out_t                   out_data
);

  // A stalled result transaction keeps its payload
  `SSR_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> $stable(out_data))

  // An accepted input keeps the block busy in the next cycle
  `SSR_ASSERT(a_busy_after_in, clk, rst_n, in_valid && !in_stall |=> in_stall)

  // A result that is not the last of its run means the run is still in progress
  `SSR_ASSERT(a_run_open, clk, rst_n, out_valid && !out_data.last_of_run |-> in_stall)

  // Reset leaves no result on the output
  `SSR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for the streaming find-and-replace block.
`timescale 1ns / 100ps

module tb;

  localparam int HOLD_DEPTH     = 8;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 45;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  // One line of the directed table: either a text transaction or a full register setting
  typedef struct packed {
    row_kind_t     kind;
    ssr_pkg::in_t  item;
    logic          typed;
    logic [3:0]    typed_n;
    logic [71:0]   typed_bytes;
    logic [63:0]   pat;
    logic [63:0]   pat_len;
    logic [63:0]   rep;
    logic [63:0]   rep_len;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  ssr_pkg::in_t                  in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  ssr_pkg::out_t                 out_data;
  logic                          cfg_we = 1'b0;
  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ssr_pkg::CFG_W-1:0]     cfg_data = '0;

  // Shadow registers and line state of the predictor
  logic [63:0] pat_reg;
  logic [3:0]  pat_len_reg;
  logic [63:0] rep_reg;
  logic [3:0]  rep_len_reg;
  logic [7:0]  held_text [0:HOLD_DEPTH-1];
  int          held_n;
  bit          line_busy;

  logic [7:0]     run_bytes [$];
  ssr_pkg::out_t  expected_bytes [$];
  stim_row_t      stim_rows [$];

  bit idle_en = 1'b1;
  int mismatches = 0;
  int quiet_cycles = 0;
  int items_in = 0;
  int bytes_out = 0;
  int settings_used = 0;

  stream_substring_replace dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int pat_len_eff();
    int n;
    n = int'(pat_len_reg);
    if (n == 0) n = 1;
    if (n > HOLD_DEPTH) n = HOLD_DEPTH;
    return n;
  endfunction

  function automatic int rep_len_eff();
    int n;
    n = int'(rep_len_reg);
    if (n > 8) n = 8;
    return n;
  endfunction

  function automatic bit held_is_pattern_prefix();
    int k;
    for (k = 0; k < held_n; k++)
      if (held_text[k] !== pat_reg[8*k +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // Emit the oldest held byte and shift the rest down
  function automatic void release_oldest();
    int k;
    run_bytes.push_back(held_text[0]);
    for (k = 1; k < held_n; k++)
      held_text[k-1] = held_text[k];
    held_n--;
  endfunction

  function automatic void flush_line();
    int k;
    for (k = 0; k < held_n; k++)
      run_bytes.push_back(held_text[k]);
    held_n = 0;
    run_bytes.push_back(ssr_pkg::NEWLINE_BYTE);
    line_busy = 1'b0;
  endfunction

  function automatic void apply_register(logic [ssr_pkg::CFG_IDX_W-1:0] idx,
                                         logic [63:0] val);
    case (idx)
      ssr_pkg::REG_PATTERN_BYTES: pat_reg = val;
      ssr_pkg::REG_PATTERN_LENGTH: begin
        pat_len_reg = val[3:0];
        // a pattern no longer than the held text drops it
        if (held_n >= pat_len_eff()) held_n = 0;
      end
      ssr_pkg::REG_REPLACEMENT_BYTES: rep_reg = val;
      ssr_pkg::REG_REPLACEMENT_LENGTH: rep_len_reg = val[3:0];
      default: ;
    endcase
  endfunction

  // Compute the bytes that one text transaction releases into run_bytes
  function automatic void predict_output_bytes(ssr_pkg::in_t it);
    int plen;
    int k;
    bit done;
    plen = pat_len_eff();
    run_bytes.delete();
    if (it.req_type == ssr_pkg::REQ_EOF) begin
      if (line_busy || held_n > 0) flush_line();
    end else if (it.data_byte == ssr_pkg::NEWLINE_BYTE) begin
      flush_line();
    end else begin
      line_busy = 1'b1;
      if (held_n >= HOLD_DEPTH) release_oldest();
      held_text[held_n] = it.data_byte;
      held_n++;
      done = 1'b0;
      while (held_n > 0 && !done) begin
        if (held_n <= plen && held_is_pattern_prefix()) begin
          if (held_n == plen) begin
            for (k = 0; k < rep_len_eff(); k++)
              run_bytes.push_back(rep_reg[8*k +: 8]);
            held_n = 0;
          end
          done = 1'b1;
        end else begin
          release_oldest();
        end
      end
    end
  endfunction

  function automatic void expect_byte(logic [7:0] b, logic last);
    ssr_pkg::out_t o;
    o.out_byte    = b;
    o.last_of_run = last;
    expected_bytes.push_back(o);
  endfunction

  function automatic void item_row(logic req, logic [7:0] b, logic typed, int n,
                                   logic [71:0] bytes);
    stim_row_t r;
    r = '0;
    r.kind           = ROW_ITEM;
    r.item.req_type  = req;
    r.item.data_byte = b;
    r.typed          = typed;
    r.typed_n        = 4'(n);
    r.typed_bytes    = bytes;
    stim_rows.push_back(r);
  endfunction

  function automatic void cfg_row(logic [63:0] pat, logic [63:0] plen, logic [63:0] rep,
                                  logic [63:0] rlen);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_CFG;
    r.pat     = pat;
    r.pat_len = plen;
    r.rep     = rep;
    r.rep_len = rlen;
    stim_rows.push_back(r);
  endfunction

  // Drive one transaction, hold it until accepted, then queue what it should produce
  task automatic send_item(ssr_pkg::in_t it, logic typed, int typed_n,
                           logic [71:0] typed_bytes);
    int k;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(negedge clk); while (in_stall !== 1'b0);
    predict_output_bytes(it);
    if (typed) begin
      for (k = 0; k < typed_n; k++)
        expect_byte(typed_bytes[8*k +: 8], k == typed_n - 1);
    end else begin
      for (k = 0; k < run_bytes.size(); k++)
        expect_byte(run_bytes[k], k == run_bytes.size() - 1);
    end
    items_in++;
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected byte, then let the block finish its run
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(logic [63:0] pat, logic [63:0] plen, logic [63:0] rep,
                            logic [63:0] rlen);
    logic [63:0] vals [4];
    int i;
    vals[0] = pat;
    vals[1] = plen;
    vals[2] = rep;
    vals[3] = rlen;
    for (i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= ssr_pkg::CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      apply_register(ssr_pkg::CFG_IDX_W'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One random register setting followed by text built mostly from pattern pieces
  task automatic random_phase(int phase, int n_items);
    logic [7:0]  letters [3];
    logic [63:0] pat;
    logic [63:0] rep;
    logic [63:0] plen_w;
    logic [63:0] rlen_w;
    int plen;
    int pick;
    int cut;
    int k;
    int sent;
    ssr_pkg::in_t it;
    for (k = 0; k < 3; k++)
      do letters[k] = 8'($urandom_range(0, 255));
      while (letters[k] == ssr_pkg::NEWLINE_BYTE);
    for (k = 0; k < 8; k++)
      pat[8*k +: 8] = letters[$urandom_range(0, 2)];
    if (phase == 5) pat = {$urandom(), $urandom()};
    plen = (phase == 0) ? 8 : (phase == 1) ? 1 : $urandom_range(1, 8);
    plen_w = {$urandom(), $urandom()};
    plen_w[3:0] = 4'(plen);
    if (plen == 1 && $urandom_range(0, 1) == 1) plen_w[3:0] = 4'd0;
    if (plen == 8 && $urandom_range(0, 1) == 1) plen_w[3:0] = 4'($urandom_range(9, 15));
    rep = {$urandom(), $urandom()};
    rlen_w = {$urandom(), $urandom()};
    rlen_w[3:0] = 4'($urandom_range(0, 15));
    set_config(pat, plen_w, rep, rlen_w);

    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // whole pattern or a prefix of it
        cut = (pick < 30) ? plen : $urandom_range(1, plen);
        for (k = 0; k < cut; k++) begin
          it.req_type  = ssr_pkg::REQ_DATA;
          it.data_byte = pat[8*k +: 8];
          send_item(it, 1'b0, 0, '0);
          sent++;
        end
      end else begin
        it.req_type = ssr_pkg::REQ_DATA;
        if (pick < 80) it.data_byte = letters[$urandom_range(0, 2)];
        else if (pick < 88) it.data_byte = 8'($urandom_range(0, 255));
        else if (pick < 95) it.data_byte = ssr_pkg::NEWLINE_BYTE;
        else begin
          it.req_type  = ssr_pkg::REQ_EOF;
          it.data_byte = 8'($urandom_range(0, 255));
        end
        // end of file on an empty line does nothing and is not counted
        if (!(it.req_type == ssr_pkg::REQ_EOF && !line_busy && held_n == 0)) sent++;
        send_item(it, 1'b0, 0, '0);
      end
    end
  endtask

  // Receiver back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted output transaction with the oldest expectation
  always @(negedge clk) begin
    ssr_pkg::out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      bytes_out++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: byte %02h last %0b", out_data.out_byte,
                   out_data.last_of_run);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte ||
            out_data.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output %0d: expected byte %02h last %0b, got byte %02h last %0b",
                     bytes_out, want.out_byte, want.last_of_run, out_data.out_byte,
                     out_data.last_of_run);
        end
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(negedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int r;
    int phase;
    pat_reg     = '0;
    pat_len_reg = 4'd1;
    rep_reg     = '0;
    rep_len_reg = 4'd0;
    held_n      = 0;
    line_busy   = 1'b0;
    for (r = 0; r < HOLD_DEPTH; r++) held_text[r] = 8'h00;

    // Reset state: pattern is a single zero byte, replacement is empty
    item_row(ssr_pkg::REQ_EOF,  8'h00, 1'b1, 0, '0);          // empty line at end of file
    item_row(ssr_pkg::REQ_DATA, 8'h41, 1'b1, 1, 72'h41);
    item_row(ssr_pkg::REQ_DATA, 8'h00, 1'b1, 0, '0);          // match deleted
    item_row(ssr_pkg::REQ_DATA, ssr_pkg::NEWLINE_BYTE, 1'b1, 1, 72'h0A);
    item_row(ssr_pkg::REQ_DATA, ssr_pkg::NEWLINE_BYTE, 1'b1, 1, 72'h0A); // empty line
    item_row(ssr_pkg::REQ_DATA, 8'hFF, 1'b1, 1, 72'hFF);
    item_row(ssr_pkg::REQ_EOF,  8'hFF, 1'b1, 1, 72'h0A);      // open last line is closed
    // Three-byte pattern, longest replacement of all ones
    cfg_row(64'h63_6261, 64'd3, '1, 64'd8);
    item_row(ssr_pkg::REQ_DATA, 8'h61, 1'b1, 0, '0);
    item_row(ssr_pkg::REQ_DATA, 8'h62, 1'b1, 0, '0);
    item_row(ssr_pkg::REQ_DATA, 8'h63, 1'b1, 8, 72'hFF_FFFF_FFFF_FFFF_FFFF);
    item_row(ssr_pkg::REQ_DATA, 8'h61, 1'b0, 0, '0);
    item_row(ssr_pkg::REQ_DATA, 8'h62, 1'b0, 0, '0);
    item_row(ssr_pkg::REQ_DATA, 8'h61, 1'b0, 0, '0);          // restart inside a partial match
    item_row(ssr_pkg::REQ_DATA, 8'h62, 1'b0, 0, '0);
    item_row(ssr_pkg::REQ_DATA, 8'h63, 1'b0, 0, '0);
    item_row(ssr_pkg::REQ_DATA, 8'h61, 1'b0, 0, '0);
    // Shorter pattern mid-line keeps the held byte; oversized replacement length
    cfg_row(64'h63_6261, 64'd2, 64'h3837_3635_3433_3231, 64'd15);
    item_row(ssr_pkg::REQ_DATA, 8'h62, 1'b0, 0, '0);
    item_row(ssr_pkg::REQ_DATA, 8'h61, 1'b0, 0, '0);
    // Zero pattern length acts as one and drops the held byte
    cfg_row('1, 64'd0, 64'd0, 64'd0);
    item_row(ssr_pkg::REQ_EOF,  8'h00, 1'b0, 0, '0);
    item_row(ssr_pkg::REQ_DATA, 8'hFF, 1'b1, 0, '0);
    item_row(ssr_pkg::REQ_EOF,  8'h5A, 1'b0, 0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (r = 0; r < stim_rows.size(); r++) begin
      if (stim_rows[r].kind == ROW_CFG) begin
        settle();
        set_config(stim_rows[r].pat, stim_rows[r].pat_len, stim_rows[r].rep,
                   stim_rows[r].rep_len);
      end else begin
        send_item(stim_rows[r].item, stim_rows[r].typed, int'(stim_rows[r].typed_n),
                  stim_rows[r].typed_bytes);
      end
    end

    // Random phases; one calm phase in the middle and one at the end
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      idle_en = !(phase == 3 || phase == RANDOM_PHASES - 1);
      random_phase(phase, PHASE_ITEMS);
    end

    settle();
    if (expected_bytes.size() != 0) mismatches++;
    $display("run: %0d input transactions, %0d output transactions, %0d register settings",
             items_in, bytes_out, settings_used);
    $display("run: %0d mismatches", mismatches);
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
